>>> rtl/core/rrlb_pkg.sv
// Package for the record ring log buffer: default sizes and command codes.
// No dependencies.
package rrlb_pkg;
  localparam int unsigned RING_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned MAX_PAYLOAD_DEF  = 48;
  localparam int unsigned OUT_CAP          = 64;
  localparam logic        CMD_WRITE        = 1'b0;
  localparam logic        CMD_READ         = 1'b1;
endpackage

>>> rtl/core/rrlb_ram.sv
// Byte-wide synchronous RAM, one write port and one registered read port.
// Depends on nothing but its parameters.
module rrlb_ram #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);
  logic [7:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/record_ring_log_buffer_unit.sv
// Top level of the record ring log buffer: staging memory, ring sequencer.
// Depends on rrlb_pkg and rrlb_ram.
//
// Usage: requests enter on in_valid/in_ready with in_command, in_record_byte
// and in_record_end. A write request (command 0) stages one record byte; the
// byte flagged record_end starts a commit that evicts old records (reading
// each one's length byte from the ring) and copies header plus payload into
// the ring, one byte a cycle. A read request (command 1) reads the length
// byte at the cursor and then streams up to 64 record bytes on
// out_valid/out_ready, out_last on the final one, or a single out_empty
// marker. A commit checks each chunk before copying it and first settles the
// clamped length when it differs from the held one; reads are paced by the
// single ring RAM port and its registered read. A stalled receiver holds the
// output register and the sequencer waits on it. Reset clears staging
// contents (valid bits), pointers and flags; ring contents stay undefined.
module record_ring_log_buffer_unit #(
  parameter int unsigned RING_BYTES   = rrlb_pkg::RING_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = rrlb_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_PAYLOAD  = rrlb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_record_byte,
  input  logic       in_record_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_empty
);
  import rrlb_pkg::*;

  localparam int unsigned STAGE = HEADER_BYTES + MAX_PAYLOAD;
  localparam int unsigned AW    = $clog2(RING_BYTES);
  localparam int unsigned SW    = $clog2(STAGE + 1);
  localparam int unsigned SIW   = $clog2(STAGE);
  localparam int unsigned PW    = AW + 1;
  localparam logic [PW-1:0] RING_P = PW'(RING_BYTES);
  localparam logic [PW-1:0] HDR_P  = PW'(HEADER_BYTES);
  localparam logic [7:0]    MAXP   = 8'(MAX_PAYLOAD);
  localparam logic [SW-1:0] STAGE_C = SW'(STAGE);
  localparam logic [6:0]    CAP     = 7'(OUT_CAP);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_EVRD, S_EVWT, S_COPY, S_RDLEN, S_RDWT, S_RDSTR,
    S_RDBYTE, S_OUTW
  } state_t;

  state_t          state_r;
  logic [STAGE-1:0] sval_r;
  logic [7:0]      len_byte_r;   // staged length byte
  logic [SW-1:0]   scnt_r;
  logic [AW-1:0]   oldest_r, wptr_r, cur_r, rs_r;
  logic            has_r, reading_r;
  logic [7:0]      total_m_r;    // payload length after clamp
  logic [SW-1:0]   done_r;       // bytes copied
  logic [SW-1:0]   chunk_end_r;  // done index where current chunk ends
  logic [AW:0]     steps_r;
  logic [6:0]      n_r, k_r;
  logic            ob_v_r, ob_last_r, ob_empty_r;
  logic [7:0]      ob_byte_r;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;

  logic            st_we;
  logic [SIW-1:0]  st_waddr, st_raddr;
  logic [7:0]      st_rdata;

  rrlb_ram #(.DEPTH(RING_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  rrlb_ram #(.DEPTH(STAGE)) u_stage (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(in_record_byte),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // wrap helper sums
  function automatic logic [AW-1:0] wrap(input logic [PW:0] v);
    logic [PW:0] r;
    r = v;
    if (r >= {1'b0, RING_P}) r = r - {1'b0, RING_P};
    if (r >= {1'b0, RING_P}) r = r - {1'b0, RING_P};
    return r[AW-1:0];
  endfunction

  logic [7:0] len_raw, len_cl;
  logic [SW-1:0] total;
  assign len_raw = sval_r[HEADER_BYTES-1] ? len_byte_r : 8'd0;
  assign len_cl  = (len_raw > MAXP) ? MAXP : len_raw;
  assign total   = SW'(HEADER_BYTES) + SW'(total_m_r);

  // free span ahead of write pointer, remaining chunk length
  logic [PW-1:0] free_span, chunk_len, rem;
  always_comb begin
    if (!has_r || oldest_r < wptr_r) free_span = RING_P - {1'b0, wptr_r};
    else free_span = {1'b0, oldest_r} - {1'b0, wptr_r};
    rem = PW'(total) - PW'(done_r);
    if ({1'b0, wptr_r} + rem > RING_P) chunk_len = RING_P - {1'b0, wptr_r};
    else chunk_len = rem;
  end

  logic [AW-1:0] lenpos_old, lenpos_cur, nxt_old, nxt_cur;
  logic [PW-1:0] span;
  assign lenpos_old = wrap({2'b0, oldest_r} + {1'b0, HDR_P} - 1'b1);
  assign lenpos_cur = wrap({2'b0, cur_r} + {1'b0, HDR_P} - 1'b1);
  assign nxt_old = wrap({2'b0, oldest_r} + {1'b0, HDR_P} + (PW+1)'(rdata));
  assign nxt_cur = wrap({2'b0, cur_r} + {1'b0, HDR_P} + (PW+1)'(rdata));
  always_comb begin
    if (cur_r < nxt_cur) span = {1'b0, nxt_cur} - {1'b0, cur_r};
    else span = RING_P - {1'b0, cur_r} + {1'b0, nxt_cur};
  end

  logic take;
  assign take = in_valid && in_ready;

  // staging port: read one byte ahead while copying
  assign st_we    = take && (in_command == CMD_WRITE) && (scnt_r < STAGE_C);
  assign st_waddr = scnt_r[SIW-1:0];
  assign st_raddr = (state_r == S_COPY) ? SIW'(done_r + 1'b1) : done_r[SIW-1:0];

  logic [7:0] sbyte;
  assign sbyte = sval_r[done_r[SIW-1:0]] ? st_rdata : 8'd0;

  // ring port
  always_comb begin
    we    = (state_r == S_COPY);
    waddr = wptr_r;
    wdata = (done_r == SW'(HEADER_BYTES-1)) ? total_m_r : sbyte;
    raddr = (state_r == S_EVRD) ? lenpos_old :
            (state_r == S_RDLEN) ? lenpos_cur : wrap({2'b0, rs_r} + (PW+1)'(k_r));
  end

  assign in_ready  = (state_r == S_IDLE) && !ob_v_r;
  assign out_valid = ob_v_r;
  assign out_byte  = ob_byte_r;
  assign out_last  = ob_last_r;
  assign out_empty = ob_empty_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sval_r <= '0; scnt_r <= '0; oldest_r <= '0; wptr_r <= '0;
      cur_r <= '0; has_r <= 1'b0; reading_r <= 1'b0; ob_v_r <= 1'b0;
      total_m_r <= '0;
    end else begin
      if (ob_v_r && out_ready && state_r != S_RDBYTE) ob_v_r <= 1'b0;
      case (state_r)
        S_IDLE: if (take) begin
          if (in_command == CMD_WRITE) begin
            if (scnt_r < STAGE_C) begin
              sval_r[scnt_r[SIW-1:0]] <= 1'b1;
              if (scnt_r == SW'(HEADER_BYTES-1)) len_byte_r <= in_record_byte;
              scnt_r <= scnt_r + 1'b1;
            end
            if (in_record_end) state_r <= S_CHK;
          end else begin
            if (!has_r || cur_r == wptr_r) begin
              cur_r <= oldest_r; reading_r <= 1'b0;
              ob_v_r <= 1'b1; ob_byte_r <= 8'd0; ob_last_r <= 1'b1; ob_empty_r <= 1'b1;
            end else begin
              reading_r <= 1'b1;
              state_r <= S_RDLEN;
            end
          end
          done_r <= '0; steps_r <= '0;
        end
        S_CHK: begin
          if (done_r == '0) total_m_r <= len_cl;
          if (done_r == '0 ? 1'b0 : done_r >= total) begin
            sval_r <= '0; scnt_r <= '0; state_r <= S_IDLE;
          end else if (done_r == '0 && total_m_r != len_cl) begin
            state_r <= S_CHK;  // wait for clamped length to settle
          end else if (free_span < chunk_len && steps_r < RING_P) begin
            state_r <= S_EVRD;
          end else begin
            chunk_end_r <= done_r + SW'(chunk_len);
            state_r <= S_COPY;
          end
        end
        S_EVRD: state_r <= S_EVWT;
        S_EVWT: begin
          oldest_r <= nxt_old; steps_r <= steps_r + 1'b1; state_r <= S_CHK;
        end
        S_COPY: begin
          done_r <= done_r + 1'b1;
          if (wptr_r == AW'(RING_BYTES-1)) wptr_r <= '0;
          else wptr_r <= wptr_r + 1'b1;
          if (done_r + 1'b1 == chunk_end_r) begin
            steps_r <= '0;
            if (!has_r) begin
              has_r <= 1'b1; oldest_r <= '0;
              if (!reading_r) cur_r <= '0;
            end else if (!reading_r) cur_r <= oldest_r;
            state_r <= S_CHK;
          end
        end
        S_RDLEN: state_r <= S_RDWT;
        S_RDWT: begin
          rs_r <= cur_r; k_r <= '0;
          n_r <= (span > PW'(CAP)) ? CAP : 7'(span);
          if (nxt_cur == cur_r) begin
            cur_r <= oldest_r; reading_r <= 1'b0;
            ob_v_r <= 1'b1; ob_byte_r <= 8'd0; ob_last_r <= 1'b1; ob_empty_r <= 1'b1;
            state_r <= S_OUTW;
          end else begin
            cur_r <= nxt_cur;
            state_r <= S_RDSTR;
          end
        end
        S_RDSTR: state_r <= S_RDBYTE;
        S_RDBYTE: if (!ob_v_r || out_ready) begin
          ob_v_r <= 1'b1; ob_byte_r <= rdata; ob_empty_r <= 1'b0;
          ob_last_r <= (k_r + 1'b1 == n_r);
          k_r <= k_r + 1'b1;
          state_r <= (k_r + 1'b1 == n_r) ? S_OUTW : S_RDSTR;
        end
        S_OUTW: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // output register holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output changed under stall");
  // empty marker is always final
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last && out_byte == 8'd0)
    else $error("empty marker malformed");
  // no request taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("accepted while output busy");
`endif
endmodule

>>> tb/record_ring_log_buffer_unit_chk.sv
// Checker for the record ring log buffer: watches both channels, predicts
// the bytes each read request returns and compares them in order.
// Depends on rrlb_pkg.
module record_ring_log_buffer_unit_chk (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_record_byte,
  input  logic       in_record_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  input  logic       out_empty,
  output int         fail_count,
  output int         beats_pending
);
  import rrlb_pkg::*;

  localparam int RING   = RING_BYTES_DEF;
  localparam int HDR    = HEADER_BYTES_DEF;
  localparam int MAXPL  = MAX_PAYLOAD_DEF;
  localparam int STAGE  = HDR + MAXPL;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } log_beat_t;

  log_beat_t  beats_due[$];
  logic [7:0] ring_mem[RING];
  logic [7:0] stage_mem[STAGE];
  int         stage_fill;
  int         oldest_pos;
  bit         ring_used;
  int         wr_pos;
  int         cursor;
  bit         reading;

  assign beats_pending = beats_due.size();

  // Reset the predicted state
  initial begin
    fail_count = 0;
    for (int i = 0; i < RING; i++) ring_mem[i] = '0;
    for (int i = 0; i < STAGE; i++) stage_mem[i] = '0;
    stage_fill = 0;
    oldest_pos = 0;
    ring_used  = 0;
    wr_pos     = 0;
    cursor     = 0;
    reading    = 0;
  end

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    fail_count++;
  endtask

  function automatic int skip_record(input int pos);
    int len_at;
    len_at = (pos + HDR - 1) % RING;
    return (pos + HDR + int'(ring_mem[len_at])) % RING;
  endfunction

  function automatic int room_ahead();
    if (!ring_used || oldest_pos < wr_pos) return RING - wr_pos;
    return oldest_pos - wr_pos;
  endfunction

  // Evict oldest records until the chunk fits, then copy it in
  task automatic place_chunk(input int from, input int n);
    int steps;
    steps = 0;
    while (room_ahead() < n && steps < RING) begin
      oldest_pos = skip_record(oldest_pos);
      steps++;
    end
    for (int i = 0; i < n; i++) ring_mem[(wr_pos + i) % RING] = stage_mem[from + i];
    wr_pos += n;
    if (!ring_used) begin
      oldest_pos = 0;
      ring_used  = 1;
    end
    if (wr_pos >= RING) wr_pos = 0;
    if (!reading) cursor = oldest_pos;
  endtask

  task automatic commit_record();
    int total;
    int done;
    int chunk;
    if (stage_mem[HDR-1] > MAXPL) stage_mem[HDR-1] = 8'(MAXPL);
    total = HDR + int'(stage_mem[HDR-1]);
    done  = 0;
    while (done < total) begin
      chunk = total - done;
      if (wr_pos + chunk > RING) chunk = RING - wr_pos;
      place_chunk(done, chunk);
      done += chunk;
    end
    for (int i = 0; i < STAGE; i++) stage_mem[i] = '0;
    stage_fill = 0;
  endtask

  task automatic push_empty();
    cursor  = oldest_pos;
    reading = 0;
    beats_due.push_back('{data: 8'h00, last: 1'b1, empty: 1'b1});
  endtask

  // Predict the bytes one read request returns
  task automatic predict_read();
    int s;
    int e;
    int span;
    int n;
    reading = 1;
    if (!ring_used || cursor == wr_pos) begin
      push_empty();
    end else begin
      s = cursor;
      cursor = skip_record(s);
      e = cursor;
      if (s == e) begin
        push_empty();
      end else begin
        span = (s < e) ? (e - s) : (RING - s + e);
        n = (span > OUT_CAP) ? OUT_CAP : span;
        for (int k = 0; k < n; k++)
          beats_due.push_back('{data: ring_mem[(s + k) % RING], last: (k == n - 1),
                                empty: 1'b0});
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // Compare results before taking new requests
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          report_mismatch("unexpected result, queue size", 0, 1);
        end else begin
          log_beat_t want;
          want = beats_due.pop_front();
          if (out_byte !== want.data) report_mismatch("out_byte", want.data, out_byte);
          if (out_last !== want.last) report_mismatch("out_last", want.last, out_last);
          if (out_empty !== want.empty) report_mismatch("out_empty", want.empty, out_empty);
        end
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_READ) begin
          predict_read();
        end else begin
          if (stage_fill < STAGE) begin
            stage_mem[stage_fill] = in_record_byte;
            stage_fill++;
          end
          if (in_record_end) commit_record();
        end
      end
    end
  end
endmodule

>>> tb/record_ring_log_buffer_unit_tb.sv
// Testbench top for the record ring log buffer: drives write and read
// requests, stalls the receiver and gives the verdict.
// Depends on rrlb_pkg, record_ring_log_buffer_unit and its checker.
module record_ring_log_buffer_unit_tb;
  import rrlb_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_REQS = 280;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_command;
  logic [7:0] in_record_byte;
  logic       in_record_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_empty;
  int         fail_count;
  int         beats_pending;
  int         idle_cycles;
  int         burst_left;
  int         req_sent;

  record_ring_log_buffer_unit uut (.*);

  record_ring_log_buffer_unit_chk chk (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Stall the receiver in phases: sometimes always ready, sometimes choppy
  always @(posedge clk) begin
    if (req_sent % 400 < 120) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("record_ring_log_buffer_unit_tb failed");
      $finish;
    end
  end

  // Hold one request until accepted, then maybe drop valid for a gap
  task automatic send_req(input logic cmd, input logic [7:0] b, input logic last_b);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_record_byte <= b;
    in_record_end  <= last_b;
    do @(posedge clk); while (!in_ready);
    req_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic read_req();
    send_req(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // One record: header, length byte, payload; may be cut short or run long
  task automatic send_record();
    int len_b;
    int count;
    int shape;
    shape = $urandom_range(0, 9);
    if (shape < 5) len_b = $urandom_range(0, 8);
    else if (shape < 8) len_b = $urandom_range(9, 48);
    else len_b = $urandom_range(49, 255);
    count = 16 + ((len_b > 48) ? 48 : len_b);
    // Cut it short (mostly right after the length byte, for a dense fill) or run it long
    if ($urandom_range(0, 3) == 0) count = 16;
    else if ($urandom_range(0, 9) == 0) count = $urandom_range(1, 15);
    else if ($urandom_range(0, 9) == 0) count += $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      if (i == 15) send_req(CMD_WRITE, 8'(len_b), i == count - 1);
      else send_req(CMD_WRITE, 8'($urandom_range(0, 255)), i == count - 1);
      if ($urandom_range(0, 15) == 0 && i != count - 1) read_req();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_WRITE;
    in_record_byte = '0;
    in_record_end  = 1'b0;
    out_ready      = 1'b1;
    idle_cycles    = 0;
    burst_left     = 0;
    req_sent       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty ring, tiny record, extreme bytes, rewind after empty
    read_req();
    send_req(CMD_WRITE, 8'hFF, 1'b1);
    read_req();
    read_req();
    read_req();
    for (int i = 0; i < 16; i++)
      send_req(CMD_WRITE, (i == 15) ? 8'hFF : 8'h00, i == 15);
    read_req();
    read_req();

    // Random records with reads mixed in
    while (req_sent < RANDOM_REQS) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) read_req();
      end else begin
        send_record();
      end
    end
    in_valid <= 1'b0;

    // Drain the remaining results
    while (beats_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("record_ring_log_buffer_unit_tb passed");
    end else begin
      $display("record_ring_log_buffer_unit_tb failed");
    end
    $finish;
  end
endmodule
